[rtl/utf16_to_utf8_transcoder_core_defines.svh]
// assertion helpers shared by the rtl
`ifndef UTF16_TO_UTF8_TRANSCODER_CORE_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define U2U_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define U2U_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/u16u8_pkg.sv]
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared constants and types for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int CAP_WIDTH  = 20;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // word index of the registers
    localparam logic REG_OUT_CAPACITY = 1'b0;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 20'hFFFFF;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_ENDIAN   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [15:0] LIM_1BYTE  = 16'h0080;
    localparam logic [15:0] LIM_2BYTE  = 16'h0800;
    localparam logic [15:0] SURR_LO    = 16'hD800;
    localparam logic [15:0] TRAIL_LO   = 16'hDC00;
    localparam logic [15:0] SURR_HI    = 16'hDFFF;
    localparam logic [15:0] ENDIAN_LO  = 16'hFFFE;

    localparam logic [7:0] PFX_CONT  = 8'h80;
    localparam logic [7:0] PFX_LEAD2 = 8'hC0;
    localparam logic [7:0] PFX_LEAD3 = 8'hE0;
    localparam logic [7:0] PFX_LEAD4 = 8'hF0;

    localparam logic [20:0] SUPP_BASE = 21'h10000;

    typedef logic [3:0][7:0] byte_quad_t;

    // results of one code unit, as loaded into the output stage
    typedef struct packed {
        logic [2:0]  num;
        byte_quad_t  bytes;
        logic        bvld;
        logic        done;
        logic [1:0]  status;
    } run_t;

endpackage

[rtl/utf16_to_utf8_transcoder_core.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// Converts a stream of UTF-16 code units to UTF-8 bytes, one byte per word.
// ----------------------------------------------------------------------------
// output: the first result word appears in the cycle after the code unit is accepted
// runs: a unit giving n results (1..4) sends them one after another over the single
//   output byte port, held while out_stall is high; a new unit is taken as the last word leaves
// reset: string state cleared, out_capacity back to 0xFFFFF, no clearing pass
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_core_defines.svh"

module utf16_to_utf8_transcoder_core #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [u16u8_pkg::PADDR_W-1:0]       paddr,
    input  logic [u16u8_pkg::PDATA_W-1:0]       pwdata,
    output logic [u16u8_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [15:0]                         code_unit,
    input  logic                                first_unit,
    input  logic                                last_unit,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          out_byte,
    output logic                                byte_valid,
    output logic                                last_of_run,
    output logic                                string_done,
    output logic [1:0]                          status,
    output logic [u16u8_pkg::CAP_WIDTH-1:0]     byte_count
);

    localparam int CW = u16u8_pkg::CAP_WIDTH;
    localparam int W  = (COUNT_WIDTH > CW) ? COUNT_WIDTH : CW;

    // ---------------- configuration ----------------
    logic [CW-1:0] cap_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= u16u8_pkg::CAP_RESET;
        end
        else if (cfg_wr && paddr[2] == u16u8_pkg::REG_OUT_CAPACITY)
        begin
            cap_reg <= pwdata[CW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == u16u8_pkg::REG_OUT_CAPACITY)
        begin
            prdata[CW-1:0] = cap_reg;
        end
    end

    // ---------------- string state ----------------
    logic                   lead_pending_reg, lead_pending_next;
    logic [9:0]             lead_bits_reg, lead_bits_next;
    logic [COUNT_WIDTH-1:0] bytes_written_reg, bytes_written_next;
    logic                   stopped_reg, stopped_next;

    // ---------------- output stage ----------------
    logic                   emit_valid_reg;
    logic [1:0]             rem_reg;
    u16u8_pkg::byte_quad_t  bytes_reg;
    logic                   bvld_reg;
    logic                   done_reg;
    logic [1:0]             status_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;

    logic                   emit_last;
    logic                   adv;
    logic                   in_acc;
    u16u8_pkg::run_t        run;
    logic [COUNT_WIDTH-1:0] cnt_first;

    assign emit_last = (rem_reg == 2'd0);
    assign adv       = emit_valid_reg && !out_stall;
    assign in_stall  = emit_valid_reg && !(emit_last && !out_stall);
    assign in_acc    = in_valid && !in_stall;

    // ---------------- decode of one code unit ----------------
    logic                   lp_e;
    logic [9:0]             lb_e;
    logic [COUNT_WIDTH-1:0] bw_e;
    logic                   st_e;
    logic [20:0]            cp;
    logic [W:0]             used_w;
    logic [W:0]             cap_m;
    logic                   no_room;
    logic                   is_trail;
    logic                   is_surr;
    logic                   err;
    logic [1:0]             err_code;
    logic [2:0]             n;
    u16u8_pkg::byte_quad_t  enc;

    always_comb
    begin
        lp_e = first_unit ? 1'b0 : lead_pending_reg;
        lb_e = first_unit ? 10'd0 : lead_bits_reg;
        bw_e = first_unit ? '0 : bytes_written_reg;
        st_e = first_unit ? 1'b0 : stopped_reg;

        is_surr  = (code_unit >= u16u8_pkg::SURR_LO) && (code_unit <= u16u8_pkg::SURR_HI);
        is_trail = (code_unit >= u16u8_pkg::TRAIL_LO) && (code_unit <= u16u8_pkg::SURR_HI);
        cp = u16u8_pkg::SUPP_BASE + {1'b0, lb_e, code_unit[9:0]};

        n   = 3'd0;
        enc = '0;
        if (lp_e)
        begin
            n = 3'd4;
            enc[0] = u16u8_pkg::PFX_LEAD4 | {5'd0, cp[20:18]};
            enc[1] = u16u8_pkg::PFX_CONT  | {2'd0, cp[17:12]};
            enc[2] = u16u8_pkg::PFX_CONT  | {2'd0, cp[11:6]};
            enc[3] = u16u8_pkg::PFX_CONT  | {2'd0, cp[5:0]};
        end
        else if (code_unit < u16u8_pkg::LIM_1BYTE)
        begin
            n = 3'd1;
            enc[0] = code_unit[7:0];
        end
        else if (code_unit < u16u8_pkg::LIM_2BYTE)
        begin
            n = 3'd2;
            enc[0] = u16u8_pkg::PFX_LEAD2 | {3'd0, code_unit[10:6]};
            enc[1] = u16u8_pkg::PFX_CONT  | {2'd0, code_unit[5:0]};
        end
        else
        begin
            n = 3'd3;
            enc[0] = u16u8_pkg::PFX_LEAD3 | {4'd0, code_unit[15:12]};
            enc[1] = u16u8_pkg::PFX_CONT  | {2'd0, code_unit[11:6]};
            enc[2] = u16u8_pkg::PFX_CONT  | {2'd0, code_unit[5:0]};
        end

        // room check: used + n > capacity, both at the counter width
        used_w  = (W+1)'(bw_e);
        cap_m   = (W+1)'(cap_reg) & {{(W+1-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
        no_room = (used_w + (W+1)'(n)) > cap_m;

        lead_pending_next = lp_e;
        lead_bits_next    = lb_e;
        bytes_written_next = bw_e;
        stopped_next      = st_e;
        run       = '0;
        cnt_first = bw_e;
        err       = 1'b0;
        err_code  = u16u8_pkg::ST_OK;

        if (!st_e)
        begin
            if (lp_e)
            begin
                if (!is_trail)
                begin
                    err      = 1'b1;
                    err_code = u16u8_pkg::ST_INVALID;
                end
            end
            else if (code_unit == 16'd0)
            begin
                // terminator: one empty result that ends the string
                stopped_next = 1'b1;
                run.num  = 3'd1;
                run.done = 1'b1;
            end
            else if (!is_surr)
            begin
                if (code_unit >= u16u8_pkg::ENDIAN_LO)
                begin
                    err      = 1'b1;
                    err_code = u16u8_pkg::ST_ENDIAN;
                end
            end
            else if (is_trail || last_unit)
            begin
                err      = 1'b1;
                err_code = u16u8_pkg::ST_INVALID;
            end

            if (!lp_e && is_surr && !is_trail && !last_unit)
            begin
                // lead held for the next unit
                lead_pending_next = 1'b1;
                lead_bits_next    = code_unit[9:0];
                run.num = 3'd1;
            end
            else if (!err && (lp_e || code_unit != 16'd0) && no_room)
            begin
                err      = 1'b1;
                err_code = u16u8_pkg::ST_OVERFLOW;
            end
            else if (!err && (lp_e || code_unit != 16'd0))
            begin
                lead_pending_next  = 1'b0;
                lead_bits_next     = 10'd0;
                bytes_written_next = bw_e + COUNT_WIDTH'(n);
                cnt_first          = bw_e + COUNT_WIDTH'(1);
                stopped_next       = last_unit;
                run.num   = n;
                run.bytes = enc;
                run.bvld  = 1'b1;
                run.done  = last_unit;
            end

            if (err)
            begin
                stopped_next      = 1'b1;
                lead_pending_next = 1'b0;
                lead_bits_next    = 10'd0;
                run.num    = 3'd1;
                run.bytes  = '0;
                run.bvld   = 1'b0;
                run.done   = 1'b1;
                run.status = err_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg  <= 1'b0;
            lead_bits_reg     <= 10'd0;
            bytes_written_reg <= '0;
            stopped_reg       <= 1'b0;
        end
        else if (in_acc)
        begin
            lead_pending_reg  <= lead_pending_next;
            lead_bits_reg     <= lead_bits_next;
            bytes_written_reg <= bytes_written_next;
            stopped_reg       <= stopped_next;
        end
    end

    // ------------ output stage: one word per cycle unless stalled ------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_valid_reg <= 1'b0;
            rem_reg        <= 2'd0;
        end
        else if (in_acc && run.num != 3'd0)
        begin
            emit_valid_reg <= 1'b1;
            rem_reg        <= 2'(run.num - 3'd1);
        end
        else if (adv)
        begin
            emit_valid_reg <= !emit_last;
            rem_reg        <= rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && run.num != 3'd0)
        begin
            bytes_reg  <= run.bytes;
            bvld_reg   <= run.bvld;
            done_reg   <= run.done;
            status_reg <= run.status;
            cnt_reg    <= cnt_first;
        end
        else if (adv && !emit_last)
        begin
            bytes_reg <= {8'd0, bytes_reg[3], bytes_reg[2], bytes_reg[1]};
            cnt_reg   <= cnt_reg + COUNT_WIDTH'(1);
        end
    end

    logic [W-1:0] cnt_w;
    assign cnt_w = W'(cnt_reg);

    assign out_valid   = emit_valid_reg;
    assign out_byte    = bytes_reg[0];
    assign byte_valid  = bvld_reg;
    assign last_of_run = emit_last;
    assign string_done = done_reg && emit_last;
    assign status      = status_reg;
    assign byte_count  = cnt_w[CW-1:0];

    // ---------------- checks ----------------
    `U2U_ASSERT_NOW(a_done_on_last, out_valid && string_done, last_of_run,
        "string_done away from the last word of a run")
    `U2U_ASSERT_NOW(a_error_word, out_valid && status != u16u8_pkg::ST_OK,
        !byte_valid && string_done, "error word carries a byte or leaves string open")
    `U2U_ASSERT_NOW(a_empty_byte_zero, out_valid && !byte_valid, out_byte == 8'd0,
        "empty word with nonzero byte")
    `U2U_ASSERT_NOW(a_hold_input, out_valid && !last_of_run, in_stall,
        "input taken while a run is still going out")
    `U2U_ASSERT_NEXT(a_drain, out_valid && last_of_run && !out_stall && !in_acc,
        !out_valid, "output stage kept a word after its run drained")

endmodule
